[design/krs_pkg.sv]
// Shared types and constants of the keyed running statistics core.
package krs_pkg;

  localparam int NumKeys    = 64;
  localparam int KeyBits    = 6;
  localparam int SampleBits = 16;
  localparam int CountBits  = 16;
  localparam int SumBits    = 33;
  localparam int SqBits     = 48;
  localparam int FifoDepth  = 4;
  localparam int FifoAw     = 2;

  typedef enum logic [1:0] {
    CmdAdd   = 2'd0,
    CmdQuery = 2'd1,
    CmdClear = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                         cmd;
    logic                         key_ok;
    logic [KeyBits-1:0]           key;
    logic signed [SampleBits-1:0] sample;
  } op_t;

  typedef struct packed {
    logic [15:0]        sample_count;
    logic signed [15:0] minimum;
    logic signed [15:0] maximum;
    logic signed [15:0] mean;
    logic [31:0]        variance;
    logic [15:0]        deviation;
    logic               has_spread;
    logic               saturated;
  } res_t;

  typedef enum logic [2:0] {
    StIdle,
    StAdd,
    StRead,
    StDiv,
    StVar,
    StSqrt,
    StOut
  } back_st_e;

endpackage

[design/krs_front.sv]
// Front end: accepts transactions, classifies them and queues operations.
module krs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [23:0]        s_tdata_i,
  output logic               op_valid_o,
  input  logic               op_ready_i,
  output krs_pkg::op_t       op_o
);

  krs_pkg::op_t               mem_q [krs_pkg::FifoDepth];
  logic [krs_pkg::FifoAw:0]   wp_q, wp_d, rp_q, rp_d;
  logic                       full, empty, push, pop;
  krs_pkg::op_t               op_in;
  logic [1:0]                 cmd_raw;
  logic [5:0]                 key_raw;

  assign cmd_raw = s_tdata_i[1:0];
  assign key_raw = s_tdata_i[7:2];

  always_comb begin
    op_in.key    = key_raw[krs_pkg::KeyBits-1:0];
    op_in.key_ok = (32'(key_raw) < krs_pkg::NumKeys);
    op_in.sample = s_tdata_i[23:8];
    unique case (cmd_raw)
      2'd0:    op_in.cmd = krs_pkg::CmdAdd;
      2'd1:    op_in.cmd = krs_pkg::CmdQuery;
      2'd2:    op_in.cmd = krs_pkg::CmdClear;
      default: op_in.cmd = krs_pkg::CmdNone;
    endcase
  end

  assign full  = (wp_q[krs_pkg::FifoAw] != rp_q[krs_pkg::FifoAw]) &&
                 (wp_q[krs_pkg::FifoAw-1:0] == rp_q[krs_pkg::FifoAw-1:0]);
  assign empty = (wp_q == rp_q);
  assign s_tready_o = !full;
  // drop unused commands here
  assign push = s_tvalid_i && !full && (op_in.cmd != krs_pkg::CmdNone);
  assign pop  = !empty && op_ready_i;
  assign op_valid_o = !empty;
  assign op_o = mem_q[rp_q[krs_pkg::FifoAw-1:0]];
  assign wp_d = push ? wp_q + 1'b1 : wp_q;
  assign rp_d = pop ? rp_q + 1'b1 : rp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q[krs_pkg::FifoAw-1:0]] <= op_in;
  end

endmodule

[design/krs_back.sv]
// Back end: entry store, read-modify-write of adds, and the query datapath.
module krs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  output logic          op_ready_o,
  input  krs_pkg::op_t  op_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output krs_pkg::res_t res_o
);

  // per-key store; a key whose count flag is clear reads as empty
  logic [krs_pkg::CountBits-1:0]         cnt_m [krs_pkg::NumKeys];
  logic [krs_pkg::NumKeys-1:0]           cval_q;
  logic [krs_pkg::NumKeys-1:0]           ovf_q;
  logic [krs_pkg::SumBits-1:0]           sum_m [krs_pkg::NumKeys];
  logic [krs_pkg::SqBits-1:0]            sq_m  [krs_pkg::NumKeys];
  logic signed [krs_pkg::SampleBits-1:0] min_m [krs_pkg::NumKeys];
  logic signed [krs_pkg::SampleBits-1:0] max_m [krs_pkg::NumKeys];

  krs_pkg::back_st_e st_q, st_d;
  krs_pkg::op_t      op_q;
  logic [krs_pkg::SumBits-1:0]           rd_sum_q;
  logic [krs_pkg::SqBits-1:0]            rd_sq_q;
  logic signed [krs_pkg::SampleBits-1:0] rd_min_q, rd_max_q;
  logic [krs_pkg::CountBits-1:0]         n_q;
  logic                                  sat_q;

  // shared restoring divider state: two quotients computed in one pass
  logic [5:0]                  it_q, it_d;
  logic [krs_pkg::SqBits-1:0]  dq_q, dq_d;   // sumsq dividend / quotient
  logic [krs_pkg::CountBits:0] dr_q, dr_d;
  logic [krs_pkg::SumBits-1:0] mq_q, mq_d;   // |sum| dividend / quotient
  logic [krs_pkg::CountBits:0] mr_q, mr_d;
  logic                        neg_q, neg_d;
  logic [31:0]                 var_q, var_d;
  // square root state
  logic [31:0] sx_q, sx_d;
  logic [31:0] sr_q, sr_d;
  logic [31:0] sb_q, sb_d;
  logic [2*krs_pkg::SampleBits-1:0] qq;
  logic [krs_pkg::SqBits-1:0]       qq_ext, vdiff;
  krs_pkg::res_t fin_q, fin_d;
  krs_pkg::res_t res_q, res_d;
  logic          rv_q, rv_d;

  logic                                  accept;
  logic [krs_pkg::CountBits:0]           dtry, mtry;
  logic [krs_pkg::SumBits-1:0]           sum_mag;
  logic [32:0]                           rtry;
  logic signed [2*krs_pkg::SampleBits-1:0] sq_s;
  logic [krs_pkg::SumBits-1:0]           smp_ext;
  logic [krs_pkg::SqBits-1:0]            sq_ext;

  assign op_ready_o  = (st_q == krs_pkg::StIdle);
  assign accept      = op_valid_i && op_ready_o;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  assign sq_s    = op_q.sample * op_q.sample;
  assign sq_ext  = {{(krs_pkg::SqBits-2*krs_pkg::SampleBits){1'b0}}, sq_s};
  assign smp_ext = {{(krs_pkg::SumBits-krs_pkg::SampleBits){op_q.sample[krs_pkg::SampleBits-1]}},
                    op_q.sample};

  // clear completes in the accept cycle; an add writes back in the cycle after
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cval_q <= '0;
      ovf_q  <= '0;
    end else if (accept && op_i.key_ok && op_i.cmd == krs_pkg::CmdClear) begin
      cval_q[op_i.key] <= 1'b0;
      ovf_q[op_i.key]  <= 1'b0;
    end else if (st_q == krs_pkg::StAdd) begin
      if (n_q == '1) ovf_q[op_q.key] <= 1'b1;
      else cval_q[op_q.key] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == krs_pkg::StAdd && n_q != '1) begin
      cnt_m[op_q.key] <= n_q + 1'b1;
      if (n_q == '0) begin
        sum_m[op_q.key] <= smp_ext;
        sq_m[op_q.key]  <= sq_ext;
        min_m[op_q.key] <= op_q.sample;
        max_m[op_q.key] <= op_q.sample;
      end else begin
        sum_m[op_q.key] <= rd_sum_q + smp_ext;
        sq_m[op_q.key]  <= rd_sq_q + sq_ext;
        min_m[op_q.key] <= (op_q.sample < rd_min_q) ? op_q.sample : rd_min_q;
        max_m[op_q.key] <= (op_q.sample > rd_max_q) ? op_q.sample : rd_max_q;
      end
    end
    if (accept) begin
      rd_sum_q <= sum_m[op_i.key];
      rd_sq_q  <= sq_m[op_i.key];
      rd_min_q <= min_m[op_i.key];
      rd_max_q <= max_m[op_i.key];
      op_q     <= op_i;
      n_q      <= (op_i.key_ok && cval_q[op_i.key]) ? cnt_m[op_i.key] : '0;
      sat_q    <= ovf_q[op_i.key];
    end
  end

  assign sum_mag = rd_sum_q[krs_pkg::SumBits-1] ? ('0 - rd_sum_q) : rd_sum_q;
  assign dtry    = {dr_q[krs_pkg::CountBits-1:0], dq_q[krs_pkg::SqBits-1]};
  assign mtry    = {mr_q[krs_pkg::CountBits-1:0], mq_q[krs_pkg::SumBits-1]};
  assign rtry    = {1'b0, sr_q} + {1'b0, sb_q};
  // the mean magnitude never exceeds the sample range
  assign qq      = mq_q[krs_pkg::SampleBits-1:0] * mq_q[krs_pkg::SampleBits-1:0];
  assign qq_ext  = {{(krs_pkg::SqBits-2*krs_pkg::SampleBits){1'b0}}, qq};
  assign vdiff   = dq_q - qq_ext;

  always_comb begin
    st_d = st_q; it_d = it_q;
    dq_d = dq_q; dr_d = dr_q; mq_d = mq_q; mr_d = mr_q; neg_d = neg_q;
    var_d = var_q; sx_d = sx_q; sr_d = sr_q; sb_d = sb_q;
    fin_d = fin_q; res_d = res_q; rv_d = rv_q;
    if (rv_q && res_ready_i) rv_d = 1'b0;
    unique case (st_q)
      krs_pkg::StIdle: begin
        if (accept) begin
          if (op_i.cmd == krs_pkg::CmdQuery) st_d = krs_pkg::StRead;
          else if (op_i.cmd == krs_pkg::CmdAdd && op_i.key_ok) st_d = krs_pkg::StAdd;
        end
      end
      krs_pkg::StAdd: begin
        st_d = krs_pkg::StIdle;
      end
      krs_pkg::StRead: begin
        if (n_q == '0) begin
          fin_d = '0;
          st_d  = krs_pkg::StOut;
        end else begin
          dq_d = rd_sq_q; dr_d = '0;
          mq_d = sum_mag; mr_d = '0;
          neg_d = rd_sum_q[krs_pkg::SumBits-1];
          it_d = 6'(krs_pkg::SqBits);
          st_d = krs_pkg::StDiv;
        end
      end
      krs_pkg::StDiv: begin
        // one quotient bit per cycle for both divisions
        if (dtry >= {1'b0, n_q}) begin
          dr_d = dtry - {1'b0, n_q}; dq_d = {dq_q[krs_pkg::SqBits-2:0], 1'b1};
        end else begin
          dr_d = dtry; dq_d = {dq_q[krs_pkg::SqBits-2:0], 1'b0};
        end
        if (it_q <= 6'(krs_pkg::SumBits)) begin
          if (mtry >= {1'b0, n_q}) begin
            mr_d = mtry - {1'b0, n_q}; mq_d = {mq_q[krs_pkg::SumBits-2:0], 1'b1};
          end else begin
            mr_d = mtry; mq_d = {mq_q[krs_pkg::SumBits-2:0], 1'b0};
          end
        end
        it_d = it_q - 1'b1;
        if (it_q == 6'd1) st_d = krs_pkg::StVar;
      end
      krs_pkg::StVar: begin
        if (dq_q <= qq_ext) var_d = '0;
        else if (|vdiff[krs_pkg::SqBits-1:32]) var_d = 32'hFFFF_FFFF;
        else var_d = vdiff[31:0];
        sx_d = var_d; sr_d = '0; sb_d = 32'h4000_0000;
        it_d = 6'd16;
        st_d = krs_pkg::StSqrt;
      end
      krs_pkg::StSqrt: begin
        if ({1'b0, sx_q} >= rtry) begin
          sx_d = sx_q - rtry[31:0];
          sr_d = (sr_q >> 1) + sb_q;
        end else begin
          sr_d = sr_q >> 1;
        end
        sb_d = sb_q >> 2;
        it_d = it_q - 1'b1;
        if (it_q == 6'd1) begin
          fin_d.sample_count = n_q;
          fin_d.minimum      = rd_min_q;
          fin_d.maximum      = rd_max_q;
          fin_d.mean         = neg_q ? 16'(33'd0 - mq_q) : mq_q[15:0];
          fin_d.variance     = var_q;
          fin_d.deviation    = sr_d[15:0];
          fin_d.has_spread   = (var_q != '0);
          fin_d.saturated    = sat_q;
          st_d = krs_pkg::StOut;
        end
      end
      krs_pkg::StOut: begin
        // hold until the output register is free or draining this cycle
        if (!rv_q || res_ready_i) begin
          res_d = fin_q;
          rv_d  = 1'b1;
          st_d  = krs_pkg::StIdle;
        end
      end
      default: st_d = krs_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= krs_pkg::StIdle;
      rv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; dq_q <= dq_d; dr_q <= dr_d; mq_q <= mq_d; mr_q <= mr_d;
    neg_q <= neg_d; var_q <= var_d; sx_q <= sx_d; sr_q <= sr_d; sb_q <= sb_d;
    fin_q <= fin_d; res_q <= res_d;
  end

endmodule

[design/keyed_running_statistics_core.sv]
// Keyed running statistics: a four-entry operation queue takes every
// transaction but drops unused commands and passes the rest to the back
// end. There a clear completes on acceptance, an add does a registered read
// of the key's entry, then a write back, and a query does a step that loads
// the divider, 48 steps of the bit-serial divider that forms sum/n and
// sumsq/n together, a step for the variance, 16 steps of the square root and
// a step that loads the output register; an empty key skips to that last
// step. A waiting result stalls the back end only when a further query has
// finished; the front end keeps taking transactions while the queue has room.
module keyed_running_statistics_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // command[1:0], key[7:2], sample[23:8]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata    // sample_count[15:0], minimum[31:16],
                                  // maximum[47:32], mean[63:48],
                                  // variance[95:64], deviation[111:96],
                                  // has_spread[112], saturated[113]
);

  logic          op_valid, op_ready;
  krs_pkg::op_t  op;
  krs_pkg::res_t res;

  krs_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready), .s_tdata_i(s_tdata),
    .op_valid_o(op_valid), .op_ready_i(op_ready), .op_o(op)
  );

  krs_back u_back (
    .clk_i, .rst_ni,
    .op_valid_i(op_valid), .op_ready_o(op_ready), .op_i(op),
    .res_valid_o(m_tvalid), .res_ready_i(m_tready), .res_o(res)
  );

  assign m_tdata = {22'd0, res.saturated, res.has_spread, res.deviation,
                    res.variance, res.mean, res.maximum, res.minimum,
                    res.sample_count};

endmodule

[design/krs_checker.sv]
// Port-level checker of the keyed running statistics core and its binding.
module krs_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");

  a_spread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[112] == (m_tdata[95:64] != 32'd0))
    else $error("spread flag disagrees with variance");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[15:0] == 16'd0 |-> m_tdata[113:16] == '0)
    else $error("empty key gave nonzero statistics");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[15:0] != 16'd0 |->
      $signed(m_tdata[31:16]) <= $signed(m_tdata[47:32]))
    else $error("minimum above maximum");

endmodule

bind keyed_running_statistics_core krs_checker u_krs_checker (
  .clk_i, .rst_ni, .m_tvalid, .m_tready, .m_tdata
);
